// ===== rtl/core/hrqs_pkg.sv =====
// Shared types and constants for the HTTP request line / query splitter.
// Holds the input and result word structs, span kind codes and delimiter bytes.
// No dependencies.
package hrqs_pkg;

  // Span kind codes carried in each result word
  localparam logic [1:0] KIND_METHOD = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_PAIR   = 2'd2;

  // Delimiter characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;

  // One input word: a byte of the request buffer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  // One result word: a span or a key/value pair
  typedef struct packed {
    logic [1:0] span_kind;
    logic [7:0] first_offset;
    logic [7:0] first_length;
    logic [7:0] value_offset;
    logic [7:0] value_length;
    logic       has_value;
    logic       last_of_run;
  } out_word_t;

  // Write strobes from the parser into the result queue
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

endpackage

// ===== rtl/core/hrqs_parser.sv =====
// Request line parser: per-byte state update and result word generation.
// Produces up to two result words per accepted byte.
// Depends on hrqs_pkg.
module hrqs_parser #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  hrqs_pkg::in_word_t  word_i,
  output hrqs_pkg::out_word_t res0_o,
  output hrqs_pkg::out_word_t res1_o,
  output hrqs_pkg::push_t     push_o
);

  localparam int PW = $clog2(BUFFER_BYTES + 1);

  typedef enum logic [1:0] {
    PH_METHOD,
    PH_TARGET,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    PP_NONE,
    PP_KEY,
    PP_VALUE
  } pair_phase_e;

  phase_e      phase_q, phase_d;
  pair_phase_e pair_q, pair_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]  tstart_q, tstart_d;
  logic [7:0]  kstart_q, kstart_d;
  logic [7:0]  vstart_q, vstart_d;

  logic       active;
  logic       in_query;
  logic [7:0] pos8;
  logic [7:0] nxt8;
  logic [7:0] c;

  hrqs_pkg::out_word_t res0, res1;
  hrqs_pkg::push_t     push;

  // Build the pair word closing at the current position
  function automatic hrqs_pkg::out_word_t make_pair(logic [7:0] kst, logic [7:0] vst,
                                                    logic [7:0] p, logic in_value);
    hrqs_pkg::out_word_t w;
    w = '0;
    w.span_kind    = hrqs_pkg::KIND_PAIR;
    w.first_offset = kst;
    if (in_value) begin
      w.first_length = vst - 8'd1 - kst;
      w.value_offset = vst;
      w.value_length = p - vst;
      w.has_value    = 1'b1;
    end else begin
      w.first_length = p - kst;
    end
    return w;
  endfunction

  assign c        = word_i.data_byte;
  assign active   = pos_q < PW'(BUFFER_BYTES);
  assign pos8     = 8'(pos_q);
  assign nxt8     = pos8 + 8'd1;
  assign in_query = (pair_q == PP_KEY) || (pair_q == PP_VALUE);

  // Next state and result words
  always_comb begin
    phase_d  = phase_q;
    pair_d   = pair_q;
    pos_d    = pos_q;
    tstart_d = tstart_q;
    kstart_d = kstart_q;
    vstart_d = vstart_q;
    res0     = '0;
    res1     = '0;
    push     = '0;

    if (accept_i && active) begin
      case (phase_q)
        PH_METHOD: begin
          if (c == hrqs_pkg::CH_SPACE) begin
            res0.span_kind    = hrqs_pkg::KIND_METHOD;
            res0.first_length = pos8;
            push.push0        = 1'b1;
            tstart_d          = nxt8;
            phase_d           = PH_TARGET;
          end
        end
        PH_TARGET: begin
          if (c == hrqs_pkg::CH_SPACE) begin
            res0.span_kind    = hrqs_pkg::KIND_TARGET;
            res0.first_offset = tstart_q;
            res0.first_length = pos8 - tstart_q;
            push.push0        = 1'b1;
            if (in_query) begin
              res1       = make_pair(kstart_q, vstart_q, pos8, pair_q == PP_VALUE);
              push.push1 = 1'b1;
            end
            phase_d = PH_DONE;
            pair_d  = PP_NONE;
          end else if (!in_query) begin
            if (c == hrqs_pkg::CH_QUEST) begin
              kstart_d = nxt8;
              pair_d   = PP_KEY;
            end
          end else if (pair_q == PP_KEY) begin
            if (c == hrqs_pkg::CH_EQUAL) begin
              vstart_d = nxt8;
              pair_d   = PP_VALUE;
            end
          end else begin
            if (c == hrqs_pkg::CH_AMP) begin
              res0       = make_pair(kstart_q, vstart_q, pos8, 1'b1);
              push.push0 = 1'b1;
              kstart_d   = nxt8;
              pair_d     = PP_KEY;
            end
          end
        end
        default: ;
      endcase
      pos_d = pos_q + PW'(1);
    end

    // Mark the final word of this byte
    if (push.push1) begin
      res1.last_of_run = 1'b1;
    end else if (push.push0) begin
      res0.last_of_run = 1'b1;
    end

    // End of buffer clears per-request state
    if (accept_i && word_i.end_of_buffer) begin
      phase_d  = PH_METHOD;
      pair_d   = PP_NONE;
      pos_d    = '0;
      tstart_d = '0;
      kstart_d = '0;
      vstart_d = '0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_METHOD;
      pair_q   <= PP_NONE;
      pos_q    <= '0;
      tstart_q <= '0;
      kstart_q <= '0;
      vstart_q <= '0;
    end else begin
      phase_q  <= phase_d;
      pair_q   <= pair_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      kstart_q <= kstart_d;
      vstart_q <= vstart_d;
    end
  end

  assign res0_o = res0;
  assign res1_o = res1;
  assign push_o = push;

`ifndef SYNTHESIS
  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push1 |-> (push.push0 && res0.span_kind == hrqs_pkg::KIND_TARGET))
    else $error("second word without target span");
  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(BUFFER_BYTES))
    else $error("position past buffer size");
  a_eob_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && word_i.end_of_buffer) |=> (pos_q == '0 && phase_q == PH_METHOD))
    else $error("end of buffer did not clear state");
`endif

endmodule

// ===== rtl/core/hrqs_out_fifo.sv =====
// Four-entry result queue: up to two words written per cycle, one read.
// Signals space for a full two-word write upstream.
// Depends on hrqs_pkg.
module hrqs_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hrqs_pkg::out_word_t res0_i,
  input  hrqs_pkg::out_word_t res1_i,
  input  hrqs_pkg::push_t     push_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hrqs_pkg::out_word_t out_word_o
);

  hrqs_pkg::out_word_t mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] wr1;
  logic [1:0] n_push;

  assign pop    = out_ready_i && (cnt_q != 3'd0);
  assign wr1    = wr_q + {1'b0, push_i.push0};
  assign n_push = {1'b0, push_i.push0} + {1'b0, push_i.push1};

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q + n_push;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, n_push} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_i.push1) begin
      mem_q[wr1] <= res1_i;
    end
  end

  assign space_o     = cnt_q <= 3'd2;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_word_o  = mem_q[rd_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue overflow");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.push0 || push_i.push1) |-> (cnt_q <= 3'd2))
    else $error("write into a full result queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 3'd4) |-> (2'(wr_q - rd_q) == cnt_q[1:0]))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

// ===== rtl/core/http_request_line_query_splitter_core.sv =====
// Throughput: one byte per cycle while input ready holds; a byte closing a
// target with a query gives two words, drained one per cycle while out_ready_i
// is high, through a four-entry result queue.
// Input ready holds while the queue has room for two words.
// Reset (rst_ni, async, active low) returns the parser to the method phase
// and empties the queue.
module http_request_line_query_splitter_core #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hrqs_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hrqs_pkg::out_word_t out_word_o
);

  logic                accept;
  logic                space;
  hrqs_pkg::out_word_t res0, res1;
  hrqs_pkg::push_t     push;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  // Byte parser
  hrqs_parser #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_word_i),
    .res0_o   (res0),
    .res1_o   (res1),
    .push_o   (push)
  );

  // Result queue
  hrqs_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res0_i      (res0),
    .res1_i      (res1),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== test/tb_http_request_line_query_splitter_core.sv =====
`timescale 1ns / 1ps
// Testbench for http_request_line_query_splitter_core: walks a table of directed
// bytes, then random request lines, and checks every result word against a local
// parser model or a row's typed result. Depends on hrqs_pkg and the core only.
module tb_http_request_line_query_splitter_core;

  localparam int BUFFER_BYTES = 256;
  localparam int ITEMS        = 1250;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int TAIL_CYCLES  = 8;

  typedef enum logic [2:0] {PH_METHOD, PH_TARGET, PH_DONE} parse_phase_e;
  typedef enum logic [1:0] {PAIR_NONE, PAIR_KEY, PAIR_VALUE} pair_phase_e;

  // One directed row: the byte, and a result typed in where it is obvious
  typedef struct packed {
    hrqs_pkg::in_word_t  word;
    logic                typed;
    hrqs_pkg::out_word_t res;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  hrqs_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_ready;
  hrqs_pkg::out_word_t out_word;

  // Typed expectation travels alongside the input word
  logic                typed_row;
  hrqs_pkg::out_word_t typed_word;

  // Parser model state
  parse_phase_e        phase_q        = PH_METHOD;
  pair_phase_e         pair_q         = PAIR_NONE;
  logic [8:0]          byte_pos       = '0;
  logic [7:0]          target_start_q = '0;
  logic [7:0]          key_start_q    = '0;
  logic [7:0]          value_start_q  = '0;
  hrqs_pkg::out_word_t step_words [2];

  hrqs_pkg::out_word_t pending_words [$];
  logic [7:0]          request_bytes [$];
  int                  mismatch_count = 0;
  int                  cycle_count    = 0;
  int                  idle_pct       = 0;
  int                  stall_pct      = 0;
  int                  random_bytes   = 0;

  dir_row_t dir_rows [25] = '{
    // method, query with pairs, '&' inside a key, second '=' inside a value
    '{'{"G", 1'b0}, 1'b0, '0},
    '{'{" ", 1'b0}, 1'b1, '{hrqs_pkg::KIND_METHOD, 8'd0, 8'd1, 8'd0, 8'd0, 1'b0, 1'b1}},
    '{'{"/", 1'b0}, 1'b0, '0},
    '{'{"?", 1'b0}, 1'b0, '0},
    '{'{"k", 1'b0}, 1'b0, '0},
    '{'{"=", 1'b0}, 1'b0, '0},
    '{'{"v", 1'b0}, 1'b0, '0},
    '{'{"&", 1'b0}, 1'b0, '0},
    '{'{"&", 1'b0}, 1'b0, '0},
    '{'{"=", 1'b0}, 1'b0, '0},
    '{'{"=", 1'b0}, 1'b0, '0},
    '{'{" ", 1'b0}, 1'b0, '0},
    '{'{"X", 1'b0}, 1'b0, '0},
    '{'{8'hFF, 1'b1}, 1'b0, '0},
    // empty method, empty final key without '='
    '{'{" ", 1'b0}, 1'b1, '{hrqs_pkg::KIND_METHOD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
    '{'{"?", 1'b0}, 1'b0, '0},
    '{'{" ", 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b0, '0},
    // buffer ends inside the target: nothing reported
    '{'{" ", 1'b0}, 1'b1, '{hrqs_pkg::KIND_METHOD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
    '{'{"?", 1'b0}, 1'b0, '0},
    '{'{"a", 1'b1}, 1'b0, '0},
    // empty target, no query
    '{'{"A", 1'b0}, 1'b0, '0},
    '{'{" ", 1'b0}, 1'b1, '{hrqs_pkg::KIND_METHOD, 8'd0, 8'd1, 8'd0, 8'd0, 1'b0, 1'b1}},
    '{'{" ", 1'b0}, 1'b1, '{hrqs_pkg::KIND_TARGET, 8'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
    '{'{8'h80, 1'b1}, 1'b0, '0}
  };

  http_request_line_query_splitter_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Method or target span word
  function automatic hrqs_pkg::out_word_t span_word(logic [1:0] kind, logic [7:0] off,
                                                    logic [7:0] len);
    hrqs_pkg::out_word_t w;
    w              = '0;
    w.span_kind    = kind;
    w.first_offset = off;
    w.first_length = len;
    return w;
  endfunction

  // Pair word closing at byte position pos
  function automatic hrqs_pkg::out_word_t pair_word(logic [7:0] pos);
    hrqs_pkg::out_word_t w;
    w              = '0;
    w.span_kind    = hrqs_pkg::KIND_PAIR;
    w.first_offset = key_start_q;
    if (pair_q == PAIR_VALUE) begin
      w.first_length = value_start_q - 8'd1 - key_start_q;
      w.value_offset = value_start_q;
      w.value_length = pos - value_start_q;
      w.has_value    = 1'b1;
    end else begin
      w.first_length = pos - key_start_q;
    end
    return w;
  endfunction

  // Advance the parser by one byte; results land in step_words, count returned
  function automatic int split_byte(hrqs_pkg::in_word_t w);
    logic [8:0] pos;
    logic [7:0] nxt;
    logic [7:0] c;
    logic       in_query;
    int         n;
    c   = w.data_byte;
    pos = byte_pos;
    n   = 0;
    if (pos < BUFFER_BYTES) begin
      nxt = pos[7:0] + 8'd1;
      case (phase_q)
        PH_METHOD: begin
          if (c == hrqs_pkg::CH_SPACE) begin
            step_words[n] = span_word(hrqs_pkg::KIND_METHOD, 8'd0, pos[7:0]);
            n++;
            target_start_q = nxt;
            phase_q        = PH_TARGET;
          end
        end
        PH_TARGET: begin
          in_query = (pair_q == PAIR_KEY) || (pair_q == PAIR_VALUE);
          if (c == hrqs_pkg::CH_SPACE) begin
            step_words[n] = span_word(hrqs_pkg::KIND_TARGET, target_start_q,
                                      pos[7:0] - target_start_q);
            n++;
            if (in_query) begin
              step_words[n] = pair_word(pos[7:0]);
              n++;
            end
            phase_q = PH_DONE;
            pair_q  = PAIR_NONE;
          end else if (!in_query) begin
            if (c == hrqs_pkg::CH_QUEST) begin
              key_start_q = nxt;
              pair_q      = PAIR_KEY;
            end
          end else if (pair_q == PAIR_KEY) begin
            if (c == hrqs_pkg::CH_EQUAL) begin
              value_start_q = nxt;
              pair_q        = PAIR_VALUE;
            end
          end else if (c == hrqs_pkg::CH_AMP) begin
            step_words[n] = pair_word(pos[7:0]);
            n++;
            key_start_q = nxt;
            pair_q      = PAIR_KEY;
          end
        end
        default: ;
      endcase
      byte_pos = pos + 9'd1;
    end
    if (n > 0) step_words[n-1].last_of_run = 1'b1;
    // end of buffer clears all per-request state
    if (w.end_of_buffer) begin
      phase_q        = PH_METHOD;
      pair_q         = PAIR_NONE;
      byte_pos       = '0;
      target_start_q = '0;
      key_start_q    = '0;
      value_start_q  = '0;
    end
    return n;
  endfunction

  task automatic check_word(hrqs_pkg::out_word_t e, hrqs_pkg::out_word_t a);
    if (a.span_kind !== e.span_kind) begin
      $error("span_kind: expected %0d, got %0d", e.span_kind, a.span_kind);
      mismatch_count++;
    end
    if (a.first_offset !== e.first_offset) begin
      $error("first_offset: expected %0d, got %0d", e.first_offset, a.first_offset);
      mismatch_count++;
    end
    if (a.first_length !== e.first_length) begin
      $error("first_length: expected %0d, got %0d", e.first_length, a.first_length);
      mismatch_count++;
    end
    if (a.value_offset !== e.value_offset) begin
      $error("value_offset: expected %0d, got %0d", e.value_offset, a.value_offset);
      mismatch_count++;
    end
    if (a.value_length !== e.value_length) begin
      $error("value_length: expected %0d, got %0d", e.value_length, a.value_length);
      mismatch_count++;
    end
    if (a.has_value !== e.has_value) begin
      $error("has_value: expected %0d, got %0d", e.has_value, a.has_value);
      mismatch_count++;
    end
    if (a.last_of_run !== e.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", e.last_of_run, a.last_of_run);
      mismatch_count++;
    end
  endtask

  // Predict on accepted input words, then check accepted result words
  always @(posedge clk) begin : track_words
    int                  n;
    hrqs_pkg::out_word_t oldest;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        n = split_byte(in_word);
        if (typed_row) pending_words.push_back(typed_word);
        else for (int i = 0; i < n; i++) pending_words.push_back(step_words[i]);
      end
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected result word %p", out_word);
          mismatch_count++;
        end else begin
          oldest = pending_words.pop_front();
          check_word(oldest, out_word);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stall bursts
  initial begin
    out_ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Offer one input word, after an optional idle burst, and wait for acceptance
  task automatic send_byte(hrqs_pkg::in_word_t w, logic typed, hrqs_pkg::out_word_t res);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_word    <= w;
    typed_row  <= typed;
    typed_word <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == hrqs_pkg::CH_SPACE);
    return c;
  endfunction

  // Query bytes lean towards the delimiters
  function automatic logic [7:0] query_char();
    case ($urandom_range(0, 9))
      0:       return hrqs_pkg::CH_EQUAL;
      1:       return hrqs_pkg::CH_AMP;
      2:       return hrqs_pkg::CH_QUEST;
      default: return plain_char();
    endcase
  endfunction

  // Request line: method, space, path, optional query, optional closing space
  task automatic build_request(int mlen, int plen, int qlen, logic closed);
    request_bytes.delete();
    repeat (mlen) request_bytes.push_back(plain_char());
    request_bytes.push_back(hrqs_pkg::CH_SPACE);
    repeat (plen) request_bytes.push_back(plain_char());
    if (qlen >= 0) begin
      request_bytes.push_back(hrqs_pkg::CH_QUEST);
      repeat (qlen) request_bytes.push_back(query_char());
    end
    if (closed) begin
      request_bytes.push_back(hrqs_pkg::CH_SPACE);
      repeat ($urandom_range(0, 3)) request_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_request();
    hrqs_pkg::in_word_t w;
    foreach (request_bytes[i]) begin
      w.data_byte     = request_bytes[i];
      w.end_of_buffer = (i == request_bytes.size() - 1);
      send_byte(w, 1'b0, '0);
      random_bytes++;
    end
  endtask

  initial begin
    int req_idx;
    int noise_len;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_word    <= '0;
    typed_row  <= 1'b0;
    typed_word <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    idle_pct  = 20;
    stall_pct = 20;
    foreach (dir_rows[i]) send_byte(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
    drain_results();

    // Random request lines
    req_idx = 0;
    while (random_bytes < ITEMS) begin
      if (random_bytes >= ITEMS - 200) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(5, 40));
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(5, 40));
      end
      if (req_idx == 0) begin
        // closing space of the method at the last position: target start wraps
        build_request(255, 4, 2, 1'b1);
      end else if (req_idx == 1) begin
        // target runs past the buffer end, its closing space is ignored
        build_request(3, 200, 80, 1'b1);
      end else begin
        case ($urandom_range(0, 15))
          0: begin
            request_bytes.delete();
            noise_len = $urandom_range(1, 40);
            repeat (noise_len)
              request_bytes.push_back(($urandom_range(0, 5) == 0) ? hrqs_pkg::CH_SPACE :
                                      8'($urandom_range(0, 255)));
          end
          1: build_request($urandom_range(240, 270), $urandom_range(0, 20),
                           $urandom_range(0, 10), 1'b1);
          2: build_request($urandom_range(0, 5), $urandom_range(0, 5),
                           int'($urandom_range(0, 7)) - 1, 1'b0);
          default: build_request($urandom_range(0, 7), $urandom_range(0, 5),
                                 ($urandom_range(0, 3) == 0) ? -1 :
                                 int'($urandom_range(0, 16)), 1'b1);
        endcase
      end
      send_request();
      if (req_idx == 20) drain_results();
      req_idx++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hrqs_pkg.sv
rtl/core/hrqs_parser.sv
rtl/core/hrqs_out_fifo.sv
rtl/core/http_request_line_query_splitter_core.sv
test/tb_http_request_line_query_splitter_core.sv
